### rtl/tksm_pkg.sv
// ----------------------------------------------------------------------------
// tksm_pkg
// shared constants and types for the top-k sum multiset unit
// ----------------------------------------------------------------------------
package tksm_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int IN_VALUE_W      = 32;
    localparam int SUM_W           = 64;
    localparam int K_W             = 7;
    localparam int COUNT_OUT_W     = 7;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_KBIG    = 2'd3;

    typedef struct packed {
        logic ins;
        logic rem;
        logic rot;
    } cell_ctl_t;

endpackage

### rtl/tksm_cell.sv
// ----------------------------------------------------------------------------
// tksm_cell
// one slot of the sorted store: holds a value, shifts it for insert,
// remove and rotate
// ----------------------------------------------------------------------------
module tksm_cell #(
    parameter int VALUE_WIDTH = tksm_pkg::DEF_VALUE_WIDTH,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
) (
    input  logic                          clk,
    input  tksm_pkg::cell_ctl_t           ctl,
    input  logic signed [VALUE_WIDTH-1:0] x,
    input  logic [CNT_W-1:0]              count,
    input  logic signed [VALUE_WIDTH-1:0] left_val,
    input  logic                          left_gt,
    input  logic signed [VALUE_WIDTH-1:0] right_val,
    output logic signed [VALUE_WIDTH-1:0] val,
    output logic                          gt,
    output logic                          eq
);
    import tksm_pkg::*;

    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic signed [VALUE_WIDTH-1:0] val_next;
    logic                          valid;
    logic                          tail;

    assign valid = CNT_W'(INDEX) < count;
    assign tail  = CNT_W'(INDEX) == count;
    assign gt    = valid && (val_reg > x);
    assign eq    = valid && (val_reg == x);
    assign val   = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.rot)
        begin
            val_next = right_val;
        end
        else if (ctl.ins && (gt || tail))
        begin
            val_next = left_gt ? left_val : x;
        end
        else if (ctl.rem && (gt || eq))
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### rtl/top_k_sum_multiset_unit.sv
// ----------------------------------------------------------------------------
// top_k_sum_multiset_unit
// bounded multiset of signed values with sum of the k largest or smallest
// ----------------------------------------------------------------------------
// Values sit in a row of CAPACITY cells kept in ascending order. An insert or
// a removal shifts the row at once; its result beat comes in the cycle after
// start and busy never rises. A query with k of zero or k above the count also
// answers in the cycle after start. Any other query rotates the whole row
// through cell zero, one cell per cycle, adding the selected entries: busy is
// high while the row rotates and falls as the beat appears. Each beat is on
// the result ports for one cycle, marked by done; the receiver cannot stall
// it. order_mode is written through cfg_we/cfg_data; the user must write it
// only while the unit is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module top_k_sum_multiset_unit #(
    parameter int CAPACITY    = tksm_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = tksm_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic                                  cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [tksm_pkg::OP_W-1:0]             opcode,
    input  logic signed [tksm_pkg::IN_VALUE_W-1:0] value,
    input  logic [tksm_pkg::K_W-1:0]              k_count,
    output logic                                  done,
    output logic signed [tksm_pkg::SUM_W-1:0]     sum_out,
    output logic [tksm_pkg::STATUS_W-1:0]         status,
    output logic [tksm_pkg::COUNT_OUT_W-1:0]      count_out
);
    import tksm_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int KX_W  = (CNT_W > K_W) ? CNT_W : K_W;

    typedef enum logic {
        S_IDLE,
        S_ROTATE
    } state_t;

    state_t                 state_reg;
    logic                   order_mode_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       rot_reg;
    logic [KX_W-1:0]        k_reg;
    logic [KX_W-1:0]        lo_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic                   done_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic signed [VALUE_WIDTH-1:0] x;
    logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]           cell_gt;
    logic [CAPACITY-1:0]           cell_eq;
    cell_ctl_t                     ctl;
    logic                          accept;
    logic                          found;
    logic                          full;
    logic [KX_W-1:0]               k_ext;
    logic [KX_W-1:0]               count_ext;
    logic [KX_W-1:0]               rot_ext;
    logic                          sel;
    logic signed [SUM_W-1:0]       term;
    logic signed [SUM_W-1:0]       acc_sum;
    logic                          rot_last;

    generate
        if (VALUE_WIDTH > IN_VALUE_W)
        begin : g_wide
            assign x = {{(VALUE_WIDTH - IN_VALUE_W){value[IN_VALUE_W-1]}}, value};
        end
        else if (VALUE_WIDTH == IN_VALUE_W)
        begin : g_same
            assign x = value;
        end
        else
        begin : g_narrow
            assign x = value[VALUE_WIDTH-1:0];
        end
    endgenerate

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign found     = |cell_eq;
    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign k_ext     = KX_W'(k_count);
    assign count_ext = KX_W'(count_reg);
    assign rot_ext   = KX_W'(rot_reg);
    assign rot_last  = (rot_reg == IDX_W'(CAPACITY - 1));

    assign ctl.ins = accept && (opcode == OP_INSERT) && !full;
    assign ctl.rem = accept && (opcode == OP_REMOVE) && found;
    assign ctl.rot = (state_reg == S_ROTATE);

    // cell zero holds original slot rot_reg during rotation
    assign sel = order_mode_reg ? (rot_ext < k_reg)
                                : ((rot_ext >= lo_reg) && (rot_ext < count_ext));
    assign term = sel ? {{(SUM_W - VALUE_WIDTH){cell_val[0][VALUE_WIDTH-1]}}, cell_val[0]}
                      : '0;
    assign acc_sum = acc_reg + term;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam int RIGHT = (i + 1) % CAPACITY;
            logic signed [VALUE_WIDTH-1:0] left_val;
            logic                          left_gt;
            if (i == 0)
            begin : g_first
                assign left_val = '0;
                assign left_gt  = 1'b0;
            end
            else
            begin : g_rest
                assign left_val = cell_val[i-1];
                assign left_gt  = cell_gt[i-1];
            end
            tksm_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .CNT_W       (CNT_W),
                .INDEX       (i)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .x         (x),
                .count     (count_reg),
                .left_val  (left_val),
                .left_gt   (left_gt),
                .right_val (cell_val[RIGHT]),
                .val       (cell_val[i]),
                .gt        (cell_gt[i]),
                .eq        (cell_eq[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            order_mode_reg <= 1'b0;
            count_reg      <= '0;
            rot_reg        <= '0;
            k_reg          <= '0;
            lo_reg         <= '0;
            acc_reg        <= '0;
            done_reg       <= 1'b0;
            sum_reg        <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                order_mode_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sum_reg    <= '0;
                        status_reg <= ST_OK;
                        done_reg   <= 1'b1;
                        case (opcode)
                            OP_INSERT:
                            begin
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (found)
                                begin
                                    count_reg <= count_reg - CNT_W'(1);
                                end
                                else
                                begin
                                    status_reg <= ST_MISSING;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (k_ext > count_ext)
                                begin
                                    status_reg <= ST_KBIG;
                                end
                                else if (k_count != '0)
                                begin
                                    done_reg  <= 1'b0;
                                    state_reg <= S_ROTATE;
                                    rot_reg   <= '0;
                                    acc_reg   <= '0;
                                    k_reg     <= k_ext;
                                    lo_reg    <= count_ext - k_ext;
                                end
                            end
                            default:
                            begin
                                status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_ROTATE:
                begin
                    acc_reg <= acc_sum;
                    rot_reg <= rot_reg + IDX_W'(1);
                    if (rot_last)
                    begin
                        state_reg <= S_IDLE;
                        sum_reg   <= acc_sum;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign sum_out   = sum_reg;
    assign status    = status_reg;
    assign count_out = COUNT_OUT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query finished without a result beat");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(count_reg))
        else $error("held count changed during rotation");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full status while store has room");

endmodule
